### hw/rtl/dtcr_pkg.sv
// ----------------------------------------------------------------------------
// dtcr_pkg
// Shared widths, register indexes and types of the depth-to-colour
// registration block.
// ----------------------------------------------------------------------------
`default_nettype none

package dtcr_pkg;

  localparam int COL_W    = 10;
  localparam int ROW_W    = 9;
  localparam int DEPTH_W  = 13;
  localparam int ADEPTH_W = 16;
  localparam int REG_W    = 64;
  localparam int ADDR_W   = 6;

  localparam int IMG_WIDTH_DEF  = 640;
  localparam int IMG_HEIGHT_DEF = 480;

  // IR point depth in Q.8 mm (gated depth below 4096 mm)
  localparam int ZI_W   = 20;
  // back-projection numerator, divider dividend, divisor and quotient
  localparam int NX_W   = 38;
  localparam int M1_W   = 38;
  localparam int D1_W   = 17;
  localparam int Q1_W   = 38;
  localparam int XI_W   = 39;
  // colour-frame coordinates and projection divisor (128 * z)
  localparam int CRD_W  = 40;
  localparam int DEN2_W = 23;

  localparam int QDEPTH = 4;

  localparam logic [2:0] REG_IR    = 3'd0;
  localparam logic [2:0] REG_COLOR = 3'd1;
  localparam logic [2:0] REG_ROT0  = 3'd2;
  localparam logic [2:0] REG_ROT1  = 3'd3;
  localparam logic [2:0] REG_ROT2  = 3'd4;

  localparam logic [DEPTH_W-1:0] DEPTH_MIN = 13'd400;
  localparam logic [DEPTH_W-1:0] DEPTH_MAX = 13'd3000;

  typedef struct packed {
    logic [REG_W-1:0]      ir;
    logic [REG_W-1:0]      color;
    logic [2:0][REG_W-1:0] rot;
  } cfg_t;

  typedef struct packed {
    logic [NX_W-1:0] nx;
    logic [NX_W-1:0] ny;
    logic [ZI_W-1:0] zi;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

`default_nettype wire

### hw/rtl/dtcr_front.sv
// ----------------------------------------------------------------------------
// dtcr_front
// Accepts pixels, drops those outside the depth gate or with a zero IR focal
// length, and forms the back-projection numerators.
// ----------------------------------------------------------------------------
`default_nettype none

module dtcr_front (
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [dtcr_pkg::COL_W-1:0]  pix_col_i,
  input  logic [dtcr_pkg::ROW_W-1:0]  pix_row_i,
  input  logic [dtcr_pkg::DEPTH_W-1:0] depth_mm_i,
  input  dtcr_pkg::cfg_t              cfg_i,
  input  dtcr_pkg::qstat_t            qstat_i,
  output logic                        push_o,
  output dtcr_pkg::entry_t            entry_o
);

  logic               pass;
  logic signed [17:0] dx, dy;
  logic signed [20:0] zi_s;
  logic signed [38:0] px, py;

  assign pass = (depth_mm_i > dtcr_pkg::DEPTH_MIN) && (depth_mm_i < dtcr_pkg::DEPTH_MAX)
              && (cfg_i.ir[63:48] != 16'd0) && (cfg_i.ir[47:32] != 16'd0);

  // offset from the principal point, Q10.6 pixels
  assign dx   = $signed({2'b00, pix_col_i, 6'b0}) - $signed({2'b00, cfg_i.ir[31:16]});
  assign dy   = $signed({3'b000, pix_row_i, 6'b0}) - $signed({2'b00, cfg_i.ir[15:0]});
  assign zi_s = $signed({1'b0, depth_mm_i[11:0], 8'b0});
  assign px   = dx * zi_s;
  assign py   = dy * zi_s;

  assign in_ready_o = !qstat_i.full;
  assign push_o     = in_valid_i && !qstat_i.full && pass;
  assign entry_o.nx = px[dtcr_pkg::NX_W-1:0];
  assign entry_o.ny = py[dtcr_pkg::NX_W-1:0];
  assign entry_o.zi = zi_s[dtcr_pkg::ZI_W-1:0];

endmodule

`default_nettype wire

### hw/rtl/dtcr_queue.sv
// ----------------------------------------------------------------------------
// dtcr_queue
// Short FIFO between the front and the back pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module dtcr_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  dtcr_pkg::entry_t  wdata_i,
  input  logic              pop_i,
  output dtcr_pkg::entry_t  rdata_o,
  output dtcr_pkg::qstat_t  qstat_o
);

  localparam int PTR_W = $clog2(dtcr_pkg::QDEPTH);

  dtcr_pkg::entry_t   mem_q [dtcr_pkg::QDEPTH];
  logic [PTR_W-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [PTR_W:0]     cnt_q, cnt_d;

  always_comb begin
    wr_d  = push_i ? wr_q + 1'b1 : wr_q;
    rd_d  = pop_i ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + (PTR_W+1)'(push_i) - (PTR_W+1)'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

  assign rdata_o       = mem_q[rd_q];
  assign qstat_o.full  = (cnt_q == (PTR_W+1)'(dtcr_pkg::QDEPTH));
  assign qstat_o.empty = (cnt_q == '0);

endmodule

`default_nettype wire

### hw/rtl/dtcr_div.sv
// ----------------------------------------------------------------------------
// dtcr_div
// Two-lane pipelined restoring divider, one quotient bit per stage. The
// dividend must stay below divisor * 2^QB.
// ----------------------------------------------------------------------------
`default_nettype none

module dtcr_div #(
  parameter int MW = 38,
  parameter int DW = 17,
  parameter int QB = 38,
  parameter int SW = 22
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [MW-1:0] num_a_i,
  input  logic [MW-1:0] num_b_i,
  input  logic [DW-1:0] den_a_i,
  input  logic [DW-1:0] den_b_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [QB-1:0] quo_a_o,
  output logic [QB-1:0] quo_b_o,
  output logic [SW-1:0] side_o
);

  logic          valid_q [QB];
  logic [MW-1:0] rem_a_q [QB];
  logic [MW-1:0] rem_b_q [QB];
  logic [DW-1:0] den_a_q [QB];
  logic [DW-1:0] den_b_q [QB];
  logic [QB-1:0] quo_a_q [QB];
  logic [QB-1:0] quo_b_q [QB];
  logic [SW-1:0] side_q  [QB];

  for (genvar k = 0; k < QB; k++) begin : g_stage
    localparam int Sh = QB - 1 - k;
    logic             v_p;
    logic [MW-1:0]    ra_p, rb_p;
    logic [DW-1:0]    da_p, db_p;
    logic [QB-1:0]    qa_p, qb_p;
    logic [SW-1:0]    s_p;
    logic [MW+DW-1:0] sa, sb, wa, wb;
    logic             ga, gb;

    if (k == 0) begin : g_first
      assign v_p  = valid_i;
      assign ra_p = num_a_i;
      assign rb_p = num_b_i;
      assign da_p = den_a_i;
      assign db_p = den_b_i;
      assign qa_p = '0;
      assign qb_p = '0;
      assign s_p  = side_i;
    end else begin : g_next
      assign v_p  = valid_q[k-1];
      assign ra_p = rem_a_q[k-1];
      assign rb_p = rem_b_q[k-1];
      assign da_p = den_a_q[k-1];
      assign db_p = den_b_q[k-1];
      assign qa_p = quo_a_q[k-1];
      assign qb_p = quo_b_q[k-1];
      assign s_p  = side_q[k-1];
    end

    assign sa = (MW+DW)'(da_p) << Sh;
    assign sb = (MW+DW)'(db_p) << Sh;
    assign wa = (MW+DW)'(ra_p);
    assign wb = (MW+DW)'(rb_p);
    assign ga = (wa >= sa);
    assign gb = (wb >= sb);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (en_i) begin
        valid_q[k] <= v_p;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_a_q[k] <= ga ? MW'(wa - sa) : ra_p;
        rem_b_q[k] <= gb ? MW'(wb - sb) : rb_p;
        quo_a_q[k] <= qa_p | (QB'(ga) << Sh);
        quo_b_q[k] <= qb_p | (QB'(gb) << Sh);
        den_a_q[k] <= da_p;
        den_b_q[k] <= db_p;
        side_q[k]  <= s_p;
      end
    end
  end

  assign valid_o = valid_q[QB-1];
  assign quo_a_o = quo_a_q[QB-1];
  assign quo_b_o = quo_b_q[QB-1];
  assign side_o  = side_q[QB-1];

endmodule

`default_nettype wire

### hw/rtl/dtcr_back.sv
// ----------------------------------------------------------------------------
// dtcr_back
// Back pipeline: back-projection divide, rotation, colour-depth gate,
// projection divide and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module dtcr_back #(
  parameter int IMG_WIDTH  = dtcr_pkg::IMG_WIDTH_DEF,
  parameter int IMG_HEIGHT = dtcr_pkg::IMG_HEIGHT_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  dtcr_pkg::cfg_t                cfg_i,
  input  dtcr_pkg::entry_t              head_i,
  input  dtcr_pkg::qstat_t              qstat_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [dtcr_pkg::COL_W-1:0]    target_col_o,
  output logic [dtcr_pkg::ROW_W-1:0]    target_row_o,
  output logic [dtcr_pkg::ADEPTH_W-1:0] aligned_depth_o
);

  localparam int QW_C = $clog2(IMG_WIDTH);
  localparam int QW_R = $clog2(IMG_HEIGHT);
  localparam int QP   = (QW_C > QW_R) ? QW_C : QW_R;
  localparam int M2_W = dtcr_pkg::DEN2_W + QP;
  localparam int S1_W = dtcr_pkg::ZI_W + 2;

  logic en;

  // stage 0: round-to-nearest numerators folded to a non-negative dividend
  logic signed [39:0]          nxe, nye, n2x, n2y;
  logic                        s0_v_q;
  logic [dtcr_pkg::M1_W-1:0]   s0_mx_q, s0_my_q;
  logic                        s0_negx_q, s0_negy_q;
  logic [dtcr_pkg::ZI_W-1:0]   s0_zi_q;

  // back-projection divider
  logic                        d1_v;
  logic [dtcr_pkg::Q1_W-1:0]   d1_qx, d1_qy;
  logic [S1_W-1:0]             d1_side;

  // rotation products
  logic signed [dtcr_pkg::XI_W-1:0] xi, yi;
  logic signed [20:0]               zi_s;
  logic signed [55:0]               prod [3][3];
  logic signed [55:0]               r1_p_q [3][3];
  logic                             r1_v_q;

  // colour-frame point
  logic signed [57:0]                acc [3];
  logic signed [dtcr_pkg::CRD_W-1:0] crd [3];
  logic signed [dtcr_pkg::CRD_W-1:0] r2_xc_q, r2_yc_q;
  logic [dtcr_pkg::ADEPTH_W-1:0]     r2_zc_q;
  logic                              r2_v_q;

  // projection products
  logic signed [56:0]            r3_pc_q, r3_pr_q;
  logic [31:0]                   r3_qc_q, r3_qr_q;
  logic [dtcr_pkg::ADEPTH_W-1:0] r3_zc_q;
  logic                          r3_v_q;

  // projection numerators and range check
  logic signed [59:0]            pc_w, pr_w, qc_w, qr_w, zz_w, nc, nr;
  logic [dtcr_pkg::DEN2_W-1:0]   den;
  logic [47:0]                   lim_c, lim_r;
  logic                          ok_c, ok_r;
  logic                          r4_v_q;
  logic [M2_W-1:0]               r4_mc_q, r4_mr_q;
  logic [dtcr_pkg::DEN2_W-1:0]   r4_den_q;
  logic [dtcr_pkg::ADEPTH_W-1:0] r4_zc_q;

  // projection divider
  logic                          d2_v;
  logic [QP-1:0]                 d2_qc, d2_qr;
  logic [dtcr_pkg::ADEPTH_W-1:0] d2_zc;

  logic                          out_v_q;
  logic [dtcr_pkg::COL_W-1:0]    out_col_q;
  logic [dtcr_pkg::ROW_W-1:0]    out_row_q;
  logic [dtcr_pkg::ADEPTH_W-1:0] out_z_q;

  // the whole back pipeline advances while the output slot is free or draining
  assign en    = !out_v_q || out_ready_i;
  assign pop_o = en && !qstat_i.empty;

  always_comb begin
    nxe = $signed(head_i.nx);
    nye = $signed(head_i.ny);
    n2x = nxe + nxe + $signed({24'b0, cfg_i.ir[63:48]});
    n2y = nye + nye + $signed({24'b0, cfg_i.ir[47:32]});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q <= 1'b0;
    end else if (en) begin
      s0_v_q <= !qstat_i.empty;
    end
  end

  // floor of a negative quotient is the complement of the quotient of the complement
  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_negx_q <= n2x[39];
      s0_negy_q <= n2y[39];
      s0_mx_q   <= n2x[39] ? ~n2x[dtcr_pkg::M1_W-1:0] : n2x[dtcr_pkg::M1_W-1:0];
      s0_my_q   <= n2y[39] ? ~n2y[dtcr_pkg::M1_W-1:0] : n2y[dtcr_pkg::M1_W-1:0];
      s0_zi_q   <= head_i.zi;
    end
  end

  dtcr_div #(
    .MW(dtcr_pkg::M1_W),
    .DW(dtcr_pkg::D1_W),
    .QB(dtcr_pkg::Q1_W),
    .SW(S1_W)
  ) u_div_ir (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s0_v_q),
    .num_a_i (s0_mx_q),
    .num_b_i (s0_my_q),
    .den_a_i ({cfg_i.ir[63:48], 1'b0}),
    .den_b_i ({cfg_i.ir[47:32], 1'b0}),
    .side_i  ({s0_negx_q, s0_negy_q, s0_zi_q}),
    .valid_o (d1_v),
    .quo_a_o (d1_qx),
    .quo_b_o (d1_qy),
    .side_o  (d1_side)
  );

  always_comb begin
    xi   = d1_side[S1_W-1] ? $signed(~{1'b0, d1_qx}) : $signed({1'b0, d1_qx});
    yi   = d1_side[S1_W-2] ? $signed(~{1'b0, d1_qy}) : $signed({1'b0, d1_qy});
    zi_s = $signed({1'b0, d1_side[dtcr_pkg::ZI_W-1:0]});
    for (int i = 0; i < 3; i++) begin
      prod[i][0] = $signed(cfg_i.rot[i][63:48]) * xi;
      prod[i][1] = $signed(cfg_i.rot[i][47:32]) * yi;
      prod[i][2] = $signed(cfg_i.rot[i][31:16]) * zi_s;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r1_v_q <= 1'b0;
      r2_v_q <= 1'b0;
      r3_v_q <= 1'b0;
      r4_v_q <= 1'b0;
    end else if (en) begin
      r1_v_q <= d1_v;
      r2_v_q <= r1_v_q && (crd[2] > 40'sd6400) && (crd[2] < 40'sd48000);
      r3_v_q <= r2_v_q;
      r4_v_q <= r3_v_q && ok_c && ok_r;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      r1_p_q <= prod;
    end
  end

  // add translation and half an LSB, then drop 18 fraction bits (floor)
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc[i] = r1_p_q[i][0] + r1_p_q[i][1] + r1_p_q[i][2]
             + $signed({cfg_i.rot[i][15:0], 14'b0}) + 58'sd131072;
      crd[i] = $signed(acc[i][57:18]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      r2_xc_q <= crd[0];
      r2_yc_q <= crd[1];
      r2_zc_q <= crd[2][dtcr_pkg::ADEPTH_W-1:0];
      r3_pc_q <= $signed({1'b0, cfg_i.color[63:48]}) * r2_xc_q;
      r3_pr_q <= $signed({1'b0, cfg_i.color[47:32]}) * r2_yc_q;
      r3_qc_q <= cfg_i.color[31:16] * r2_zc_q;
      r3_qr_q <= cfg_i.color[15:0] * r2_zc_q;
      r3_zc_q <= r2_zc_q;
    end
  end

  // numerator 2*(f*p + c*z) + 64*z over divisor 128*z gives the rounded target
  always_comb begin
    pc_w  = r3_pc_q;
    pr_w  = r3_pr_q;
    qc_w  = $signed({28'b0, r3_qc_q});
    qr_w  = $signed({28'b0, r3_qr_q});
    zz_w  = $signed({38'b0, r3_zc_q, 6'b0});
    nc    = pc_w + pc_w + qc_w + qc_w + zz_w;
    nr    = pr_w + pr_w + qr_w + qr_w + zz_w;
    den   = {r3_zc_q, 7'b0};
    lim_c = 48'(IMG_WIDTH) * 48'(den);
    lim_r = 48'(IMG_HEIGHT) * 48'(den);
    ok_c  = !nc[59] && (nc[58:0] < 59'(lim_c));
    ok_r  = !nr[59] && (nr[58:0] < 59'(lim_r));
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      r4_mc_q  <= nc[M2_W-1:0];
      r4_mr_q  <= nr[M2_W-1:0];
      r4_den_q <= den;
      r4_zc_q  <= r3_zc_q;
    end
  end

  dtcr_div #(
    .MW(M2_W),
    .DW(dtcr_pkg::DEN2_W),
    .QB(QP),
    .SW(dtcr_pkg::ADEPTH_W)
  ) u_div_proj (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (r4_v_q),
    .num_a_i (r4_mc_q),
    .num_b_i (r4_mr_q),
    .den_a_i (r4_den_q),
    .den_b_i (r4_den_q),
    .side_i  (r4_zc_q),
    .valid_o (d2_v),
    .quo_a_o (d2_qc),
    .quo_b_o (d2_qr),
    .side_o  (d2_zc)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= d2_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_col_q <= dtcr_pkg::COL_W'(d2_qc);
      out_row_q <= dtcr_pkg::ROW_W'(d2_qr);
      out_z_q   <= d2_zc;
    end
  end

  assign out_valid_o     = out_v_q;
  assign target_col_o    = out_col_q;
  assign target_row_o    = out_row_q;
  assign aligned_depth_o = out_z_q;

endmodule

`default_nettype wire

### hw/rtl/depth_to_color_registration.sv
// ----------------------------------------------------------------------------
// depth_to_color_registration
// Maps depth pixels from the IR camera onto the colour camera image.
// ----------------------------------------------------------------------------
// Each accepted depth pixel whose depth lies strictly between 400 and 3000 mm
// is back-projected with the IR intrinsics, rotated and translated into the
// colour frame, gated on a colour-frame depth strictly between 0.4 m and 3 m,
// and projected with the colour intrinsics (round to nearest). Only pixels that
// land inside IMG_WIDTH x IMG_HEIGHT give an item on the output; all others
// are accepted and dropped, so the output carries no more items than the input.
// One pixel is taken per clock while the output is drained. The two dividers
// are bit-per-stage pipelines: 38 stages for the back-projection and 10 for
// the projection at 640x480. A four-entry queue decouples input acceptance
// from output stalls. Registers sit at byte addresses 8*i (ir, color,
// rot_row0..2), 64 bits each, reset to zero; write them only while no pixel
// is in flight. Resolving several pixels landing on one target and clearing
// the aligned image is the job of the consumer memory.
// ----------------------------------------------------------------------------
`default_nettype none

module depth_to_color_registration #(
  parameter int IMG_WIDTH  = dtcr_pkg::IMG_WIDTH_DEF,
  parameter int IMG_HEIGHT = dtcr_pkg::IMG_HEIGHT_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dtcr_pkg::ADDR_W-1:0]   paddr,
  input  logic [dtcr_pkg::REG_W-1:0]    pwdata,
  output logic [dtcr_pkg::REG_W-1:0]    prdata,
  output logic                          pready,
  // depth pixel input
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [dtcr_pkg::COL_W-1:0]    pix_col_i,
  input  logic [dtcr_pkg::ROW_W-1:0]    pix_row_i,
  input  logic [dtcr_pkg::DEPTH_W-1:0]  depth_mm_i,
  // registered pixel output
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [dtcr_pkg::COL_W-1:0]    target_col_o,
  output logic [dtcr_pkg::ROW_W-1:0]    target_row_o,
  output logic [dtcr_pkg::ADEPTH_W-1:0] aligned_depth_o
);

  dtcr_pkg::cfg_t   cfg_q;
  logic [2:0]       reg_idx;
  logic             wr_en;
  dtcr_pkg::qstat_t qstat;
  dtcr_pkg::entry_t push_entry, head;
  logic             push, pop;

  // register index from the 8-byte slot; low address bits ignored
  assign reg_idx = paddr[5:3];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        dtcr_pkg::REG_IR:    cfg_q.ir     <= pwdata;
        dtcr_pkg::REG_COLOR: cfg_q.color  <= pwdata;
        dtcr_pkg::REG_ROT0:  cfg_q.rot[0] <= pwdata;
        dtcr_pkg::REG_ROT1:  cfg_q.rot[1] <= pwdata;
        dtcr_pkg::REG_ROT2:  cfg_q.rot[2] <= pwdata;
        default: ;
      endcase
    end
  end

  // read back; unmapped slots return zero
  always_comb begin
    unique case (reg_idx)
      dtcr_pkg::REG_IR:    prdata = cfg_q.ir;
      dtcr_pkg::REG_COLOR: prdata = cfg_q.color;
      dtcr_pkg::REG_ROT0:  prdata = cfg_q.rot[0];
      dtcr_pkg::REG_ROT1:  prdata = cfg_q.rot[1];
      dtcr_pkg::REG_ROT2:  prdata = cfg_q.rot[2];
      default:             prdata = '0;
    endcase
  end

  // front: gate the depth and form numerators; drop rejected pixels here
  dtcr_front u_front (
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .pix_col_i  (pix_col_i),
    .pix_row_i  (pix_row_i),
    .depth_mm_i (depth_mm_i),
    .cfg_i      (cfg_q),
    .qstat_i    (qstat),
    .push_o     (push),
    .entry_o    (push_entry)
  );

  // hold surviving pixels while the back pipeline stalls
  dtcr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_entry),
    .pop_i   (pop),
    .rdata_o (head),
    .qstat_o (qstat)
  );

  // back: divide, rotate, project, advance into the output register
  dtcr_back #(
    .IMG_WIDTH  (IMG_WIDTH),
    .IMG_HEIGHT (IMG_HEIGHT)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .head_i          (head),
    .qstat_i         (qstat),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .target_col_o    (target_col_o),
    .target_row_o    (target_row_o),
    .aligned_depth_o (aligned_depth_o)
  );

endmodule

`default_nettype wire
